// ----- rtl/mtq_pkg.sv -----
package mtq_pkg;

    localparam int MTQ_DEPTH = 1024;
    localparam int VAL_W     = 32;

    // action codes
    localparam logic [1:0] ACT_ENQ = 2'd0;
    localparam logic [1:0] ACT_DEQ = 2'd1;
    localparam logic [1:0] ACT_QRY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic enq_start;  // store value, start the max-deque rear scan
        logic enq_step;   // one compare/pop step on the deque rear
        logic deq_fin;    // pop the oldest value and adjust the front pair
        logic qry_fin;    // report the front key
        logic rep_full;   // report a dropped value
        logic rep_empty;  // report an empty queue
    } t_cmd;

    typedef struct packed {
        logic fifo_empty;
        logic fifo_full;
        logic deque_empty;
        logic enq_done;   // the current rear step finishes the enqueue
    } t_sts;

endpackage

// ----- rtl/max_tracking_queue_unit.sv -----
// FIFO queue of 32-bit values that also reports its current maximum. Issue a
// command with start while busy is low: enqueue, dequeue or query max. The
// result appears for one cycle with o_strobe, the cycle after the command
// finishes; the receiver cannot stall it, so capture it on that edge. A
// successful enqueue and the unused action code give no result. Errors (full,
// empty) do not raise busy; dequeue and query hold busy while they wait on
// the registered read of the value store and the max store. An enqueue on a
// nonempty max store holds busy while the rear scan compares one stored pair
// per cycle; each value is removed from that store at most once.
module max_tracking_queue_unit import mtq_pkg::*; #(
    parameter int DEPTH = MTQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_action,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_strobe,
    output logic [VAL_W-1:0] o_result_value,
    output logic [1:0]       o_status
);

    t_cmd cmd;
    t_sts sts;

    mtq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    mtq_datapath #(.DEPTH(DEPTH)) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .o_sts          (sts),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule

// ----- rtl/mtq_ram.sv -----
module mtq_ram import mtq_pkg::*; #(
    parameter int WIDTH = VAL_W,
    parameter int DEPTH = MTQ_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mtq_ctrl.sv -----
module mtq_ctrl import mtq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_action,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ENQ  = 4'b0010,
        S_DEQ  = 4'b0100,
        S_QRY  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        ACT_ENQ: begin
                            if (i_sts.fifo_full) begin
                                o_cmd.rep_full = 1'b1;
                            end else begin
                                o_cmd.enq_start = 1'b1;
                                // empty deque: the pair is pushed right away
                                if (!i_sts.deque_empty) begin
                                    n_state = S_ENQ;
                                end
                            end
                        end
                        ACT_DEQ: begin
                            if (i_sts.fifo_empty) begin
                                o_cmd.rep_empty = 1'b1;
                            end else begin
                                n_state = S_DEQ;
                            end
                        end
                        ACT_QRY: begin
                            if (i_sts.fifo_empty) begin
                                o_cmd.rep_empty = 1'b1;
                            end else begin
                                n_state = S_QRY;
                            end
                        end
                        default: begin
                            // unused action code: drop the beat
                        end
                    endcase
                end
            end
            S_ENQ: begin
                o_cmd.enq_step = 1'b1;
                if (i_sts.enq_done) begin
                    n_state = S_IDLE;
                end
            end
            S_DEQ: begin
                o_cmd.deq_fin = 1'b1;
                n_state       = S_IDLE;
            end
            S_QRY: begin
                o_cmd.qry_fin = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/mtq_datapath.sv -----
module mtq_datapath import mtq_pkg::*; #(
    parameter int DEPTH = MTQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [VAL_W-1:0] i_value,
    output t_sts             o_sts,
    output logic             o_strobe,
    output logic [VAL_W-1:0] o_result_value,
    output logic [1:0]       o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = VAL_W + CW;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] prv(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
    endfunction

    logic [AW-1:0]    r_head, n_head, r_tail, n_tail;
    logic [AW-1:0]    r_front, n_front, r_rear, n_rear, r_last, n_last;
    logic [CW-1:0]    r_count, n_count, r_dcount, n_dcount;
    logic [VAL_W-1:0] r_val, n_val;
    logic [CW-1:0]    r_merged, n_merged;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_value, n_out_value;
    logic [1:0]       r_out_status, n_out_status;

    logic             fifo_we;
    logic [VAL_W-1:0] fifo_rdata;
    logic             dq_we;
    logic [AW-1:0]    dq_waddr, dq_raddr;
    logic [DW-1:0]    dq_wdata, dq_rdata;
    logic [VAL_W-1:0] dq_key;
    logic [CW-1:0]    dq_cnt, cnt_sum, cnt_dec;
    logic             key_gt;

    mtq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (r_tail),
        .i_wdata (i_value),
        .i_raddr (r_head),
        .o_rdata (fifo_rdata)
    );

    mtq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_deque_ram (
        .i_clk   (i_clk),
        .i_we    (dq_we),
        .i_waddr (dq_waddr),
        .i_wdata (dq_wdata),
        .i_raddr (dq_raddr),
        .o_rdata (dq_rdata)
    );

    assign dq_key  = dq_rdata[DW-1:CW];
    assign dq_cnt  = dq_rdata[CW-1:0];
    assign key_gt  = (dq_key > r_val);
    assign cnt_sum = r_merged + dq_cnt;
    assign cnt_dec = (dq_cnt != '0) ? dq_cnt - CW'(1) : '0;

    assign o_sts.fifo_empty  = (r_count == '0);
    assign o_sts.fifo_full   = (r_count == CW'(DEPTH));
    assign o_sts.deque_empty = (r_dcount == '0);
    assign o_sts.enq_done    = key_gt || (r_dcount == CW'(1));

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_front      = r_front;
        n_rear       = r_rear;
        n_last       = r_last;
        n_count      = r_count;
        n_dcount     = r_dcount;
        n_val        = r_val;
        n_merged     = r_merged;
        n_out_valid  = 1'b0;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        fifo_we      = 1'b0;
        dq_we        = 1'b0;
        dq_waddr     = r_rear;
        dq_wdata     = {r_val, r_merged};
        dq_raddr     = r_front;

        if (i_cmd.enq_start) begin
            fifo_we  = 1'b1;
            n_tail   = nxt(r_tail);
            n_count  = r_count + CW'(1);
            n_val    = i_value;
            n_merged = CW'(1);
            if (r_dcount == '0) begin
                dq_we    = 1'b1;
                dq_wdata = {i_value, CW'(1)};
                n_rear   = nxt(r_rear);
                n_dcount = CW'(1);
            end else begin
                dq_raddr = prv(r_rear);
                n_last   = prv(r_rear);
            end
        end

        if (i_cmd.enq_step) begin
            if (key_gt) begin
                // rear pair is larger: push behind it
                dq_we    = 1'b1;
                n_rear   = nxt(r_rear);
                n_dcount = r_dcount + CW'(1);
            end else if (r_dcount == CW'(1)) begin
                // last pair popped: the merged pair takes its slot
                dq_we    = 1'b1;
                dq_waddr = r_last;
                dq_wdata = {r_val, cnt_sum};
            end else begin
                n_merged = cnt_sum;
                n_rear   = r_last;
                n_dcount = r_dcount - CW'(1);
                dq_raddr = prv(r_last);
                n_last   = prv(r_last);
            end
        end

        if (i_cmd.deq_fin) begin
            n_out_valid  = 1'b1;
            n_out_value  = fifo_rdata;
            n_out_status = ST_OK;
            n_head       = nxt(r_head);
            n_count      = r_count - CW'(1);
            if (r_dcount != '0) begin
                if (cnt_dec == '0) begin
                    n_front  = nxt(r_front);
                    n_dcount = r_dcount - CW'(1);
                end else begin
                    dq_we    = 1'b1;
                    dq_waddr = r_front;
                    dq_wdata = {dq_key, cnt_dec};
                end
            end
        end

        if (i_cmd.qry_fin) begin
            n_out_valid  = 1'b1;
            n_out_value  = (r_dcount != '0) ? dq_key : '0;
            n_out_status = ST_OK;
        end

        if (i_cmd.rep_full) begin
            n_out_valid  = 1'b1;
            n_out_value  = '0;
            n_out_status = ST_FULL;
        end

        if (i_cmd.rep_empty) begin
            n_out_valid  = 1'b1;
            n_out_value  = '0;
            n_out_status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_front     <= '0;
            r_rear      <= '0;
            r_count     <= '0;
            r_dcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_count     <= n_count;
            r_dcount    <= n_dcount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last       <= n_last;
        r_val        <= n_val;
        r_merged     <= n_merged;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_strobe       = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

// ----- rtl/mtq_checker.sv -----
module mtq_checker import mtq_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       i_action,
    input logic             o_strobe,
    input logic [VAL_W-1:0] o_result_value,
    input logic [1:0]       o_status
);

    logic accept;
    assign accept = start && !busy;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status == ST_OK || o_status == ST_EMPTY || o_status == ST_FULL))
        else $error("result with an undefined status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_result_value == '0))
        else $error("error result carries a nonzero value");

    a_read_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_DEQ || i_action == ACT_QRY)) |=> (o_strobe || busy))
        else $error("dequeue or query beat neither reported nor in progress");

    a_unused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action != ACT_ENQ && i_action != ACT_DEQ && i_action != ACT_QRY)
        |=> (!busy && !o_strobe))
        else $error("unused action code caused activity");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> $past(start || busy))
        else $error("result without a preceding command");

endmodule

bind max_tracking_queue_unit mtq_checker u_mtq_checker (.*);

// ----- tb/max_tracking_queue_unit_test.sv -----
module max_tracking_queue_unit_test;
    import mtq_pkg::*;

    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int NUM_ITEMS = 1900;

    typedef struct {
        logic [1:0]       action;
        logic [VAL_W-1:0] value;
    } queue_cmd_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [1:0]       status;
    } queue_result_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_action;
    logic [VAL_W-1:0] i_value;
    logic             o_strobe;
    logic [VAL_W-1:0] o_result_value;
    logic [1:0]       o_status;

    max_tracking_queue_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // shadow of the queue and of its max deque
    logic [VAL_W-1:0] fifo_mem [MTQ_DEPTH];
    int               fifo_head, fifo_tail, fifo_fill;
    logic [VAL_W-1:0] peak_key [MTQ_DEPTH];
    int               peak_cnt [MTQ_DEPTH];
    int               peak_front, peak_rear, peak_fill;

    queue_cmd_t    cmd_backlog [$];
    queue_result_t expected_results [$];
    queue_cmd_t    next_cmd;
    queue_result_t due;
    int            total_cmds;
    int            issued_cmds;
    int            mismatch_count;
    int            result_index;

    // stimulus bookkeeping
    int               gen_fill;
    int               counted_cmds;
    logic [VAL_W-1:0] run_val;

    task automatic apply_queue_op(input logic [1:0] act, input logic [VAL_W-1:0] val);
        queue_result_t r;
        bit            emit;
        int            merged;
        int            last;
        emit     = 1'b1;
        r.value  = '0;
        r.status = ST_OK;
        case (act)
            ACT_ENQ: begin
                if (fifo_fill >= MTQ_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    emit = 1'b0;
                    fifo_mem[fifo_tail] = val;
                    fifo_tail = (fifo_tail + 1) % MTQ_DEPTH;
                    fifo_fill++;
                    merged = 1;
                    // pop rear pairs not above the new value, fold their counts
                    while (peak_fill > 0) begin
                        last = (peak_rear + MTQ_DEPTH - 1) % MTQ_DEPTH;
                        if (peak_key[last] > val) break;
                        merged += peak_cnt[last];
                        peak_rear = last;
                        peak_fill--;
                    end
                    peak_key[peak_rear] = val;
                    peak_cnt[peak_rear] = merged;
                    peak_rear = (peak_rear + 1) % MTQ_DEPTH;
                    peak_fill++;
                end
            end
            ACT_DEQ: begin
                if (fifo_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = fifo_mem[fifo_head];
                    fifo_head = (fifo_head + 1) % MTQ_DEPTH;
                    fifo_fill--;
                    if (peak_fill > 0) begin
                        if (peak_cnt[peak_front] > 0) peak_cnt[peak_front]--;
                        if (peak_cnt[peak_front] == 0) begin
                            peak_front = (peak_front + 1) % MTQ_DEPTH;
                            peak_fill--;
                        end
                    end
                end
            end
            ACT_QRY: begin
                if (fifo_fill == 0) r.status = ST_EMPTY;
                else if (peak_fill > 0) r.value = peak_key[peak_front];
            end
            default: emit = 1'b0;
        endcase
        if (emit) expected_results.push_back(r);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return $urandom;
        if (sel < 75) return VAL_W'($urandom_range(7));
        if (sel < 85) begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        // descending run builds a long deque for a later big value to sweep
        run_val = run_val - VAL_W'($urandom_range(3));
        return run_val;
    endfunction

    function automatic logic [1:0] pick_action(input int w_enq, input int w_deq,
                                               input int w_qry);
        int sel;
        sel = $urandom_range(99);
        if (sel < w_enq) return ACT_ENQ;
        if (sel < w_enq + w_deq) return ACT_DEQ;
        if (sel < w_enq + w_deq + w_qry) return ACT_QRY;
        return ACT_NOP;
    endfunction

    task automatic push_cmd(input logic [1:0] act, input logic [VAL_W-1:0] val);
        queue_cmd_t c;
        c.action = act;
        c.value  = val;
        cmd_backlog.push_back(c);
        if (act == ACT_ENQ && gen_fill < MTQ_DEPTH) gen_fill++;
        if (act == ACT_DEQ && gen_fill > 0) gen_fill--;
        if (act != ACT_NOP) counted_cmds++;
    endtask

    function automatic int idle_pct();
        if (issued_cmds < total_cmds / 3) return 27;
        if (issued_cmds < 2 * total_cmds / 3) return 74;
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_queue_op(i_action, i_value);
            end
            // hold the beat while busy, else launch the next one or idle
            if (!start || busy === 1'b0) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct()) begin
                    next_cmd = cmd_backlog.pop_front();
                    start    <= 1'b1;
                    i_action <= next_cmd.action;
                    i_value  <= next_cmd.value;
                    issued_cmds++;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d unexpected: value %h status %0d",
                             result_index, o_result_value, o_status);
            end else begin
                due = expected_results.pop_front();
                if (o_strobe !== 1'b1 || o_result_value !== due.value ||
                    o_status !== due.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: expected value %h status %0d, ",
                                  "got value %h status %0d"},
                                 result_index, due.value, due.status,
                                 o_result_value, o_status);
                end
            end
            result_index++;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_action       = ACT_ENQ;
        i_value        = '0;
        fifo_head      = 0;
        fifo_tail      = 0;
        fifo_fill      = 0;
        peak_front     = 0;
        peak_rear      = 0;
        peak_fill      = 0;
        issued_cmds    = 0;
        mismatch_count = 0;
        result_index   = 0;
        gen_fill       = 0;
        counted_cmds   = 0;
        run_val        = 32'hFFFF_FF00;

        // empty queue, ignored code, extremes, equal keys merging
        push_cmd(ACT_DEQ, $urandom);
        push_cmd(ACT_QRY, $urandom);
        push_cmd(ACT_NOP, $urandom);
        push_cmd(ACT_ENQ, '0);
        push_cmd(ACT_QRY, $urandom);
        push_cmd(ACT_ENQ, '1);
        push_cmd(ACT_ENQ, '1);
        push_cmd(ACT_ENQ, 32'd5);
        push_cmd(ACT_QRY, $urandom);
        push_cmd(ACT_DEQ, $urandom);
        push_cmd(ACT_QRY, $urandom);
        push_cmd(ACT_DEQ, $urandom);
        push_cmd(ACT_DEQ, $urandom);
        push_cmd(ACT_QRY, $urandom);
        push_cmd(ACT_DEQ, $urandom);
        push_cmd(ACT_DEQ, $urandom);
        push_cmd(ACT_ENQ, 32'd7);
        push_cmd(ACT_ENQ, 32'd3);
        push_cmd(ACT_ENQ, 32'd7);
        push_cmd(ACT_NOP, $urandom);
        push_cmd(ACT_QRY, $urandom);
        push_cmd(ACT_DEQ, $urandom);
        push_cmd(ACT_DEQ, $urandom);
        push_cmd(ACT_DEQ, $urandom);
        push_cmd(ACT_QRY, $urandom);

        while (counted_cmds < 320) push_cmd(pick_action(40, 35, 20), pick_value());
        // fill to capacity, then knock on the full queue
        while (gen_fill < MTQ_DEPTH) push_cmd(pick_action(90, 0, 10), pick_value());
        repeat (6) push_cmd(ACT_ENQ, pick_value());
        repeat (150) push_cmd(pick_action(50, 30, 18), pick_value());
        while (counted_cmds < NUM_ITEMS) push_cmd(pick_action(20, 60, 18), pick_value());
        total_cmds = cmd_backlog.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start !== 1'b0 || busy !== 1'b0 ||
               expected_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
